@@ sv/upcal_pkg.sv @@
// ----------------------------------------------------------------------------
// upcal_pkg
// Shared types, constants and the constant-divisor step for the up-time
// calendar counter.
// ----------------------------------------------------------------------------
`default_nettype none

package upcal_pkg;

	// day counter width
	localparam int DAY_BITS = 16;

	// field widths
	localparam int MS_W    = 10;
	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int MON_W   = 4;
	localparam int YEAR_W  = 16;
	localparam int TICK_W  = 32;
	localparam int TMS_W   = 16;
	localparam int MDAY_W  = 5;
	localparam int DAYO_W  = 16;
	localparam int CDATA_W = 16;

	// elapsed ticks times tick_ms, full width
	localparam int PROD_W  = TICK_W + TMS_W;

	// time constants
	localparam int MS_PER_SEC   = 1000;
	localparam int SEC_PER_MIN  = 60;
	localparam int MIN_PER_HOUR = 60;
	localparam int HOUR_PER_DAY = 24;
	localparam int SEC_MAX      = 59;
	localparam int MIN_MAX      = 59;
	localparam int HOUR_MAX     = 23;
	localparam int MON_MAX      = 11;
	localparam int MON_PER_YEAR = 12;

	// iterative divider: dividend register, digit per cycle, remainder
	localparam int DVD_W     = 40;
	localparam int DIG_W     = 8;
	localparam int DIV_ITERS = DVD_W / DIG_W;
	localparam int ITER_W    = $clog2(DIV_ITERS);
	localparam int REM_W     = 10;

	// queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SEC  = 1'b1
	} op_t;

	typedef enum logic {
		REG_TICK_MS    = 1'b0,
		REG_MONTH_DAYS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_MS,
		ST_SEC,
		ST_MIN,
		ST_HOUR
	} stage_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} bk_state_t;

	typedef struct packed {
		op_t                 op;
		logic [TICK_W-1:0]   add;
	} qent_t;

	typedef struct packed {
		logic                push;
		qent_t               data;
	} qwr_t;

	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [DIG_W-1:0]    q;
	} step_t;

	typedef struct packed {
		logic [MS_W-1:0]     millis;
		logic [SEC_W-1:0]    seconds;
		logic [MIN_W-1:0]    minutes;
		logic [HOUR_W-1:0]   hours;
		logic [DAYO_W-1:0]   days;
		logic [MON_W-1:0]    months;
		logic [YEAR_W-1:0]   years;
	} res_t;

	function automatic logic [REM_W-1:0] div_const(stage_t st);
		logic [REM_W-1:0] d;
		case (st)
			ST_MS:   d = REM_W'(MS_PER_SEC);
			ST_SEC:  d = REM_W'(SEC_PER_MIN);
			ST_MIN:  d = REM_W'(MIN_PER_HOUR);
			ST_HOUR: d = REM_W'(HOUR_PER_DAY);
			default: d = REM_W'(MS_PER_SEC);
		endcase
		return d;
	endfunction

	// one digit of restoring long division by a small constant
	function automatic step_t div_step(logic [REM_W-1:0] rem, logic [DIG_W-1:0] digit,
			logic [REM_W-1:0] dvs);
		logic [REM_W:0]   r1;
		logic [REM_W-1:0] r;
		step_t            s;
		r = rem;
		s.q = '0;
		for (int i = DIG_W - 1; i >= 0; i--) begin
			r1 = {r, digit[i]};
			if (r1 >= {1'b0, dvs}) begin
				r1 = r1 - {1'b0, dvs};
				s.q[i] = 1'b1;
			end
			r = r1[REM_W-1:0];
		end
		s.rem = r;
		return s;
	endfunction

endpackage

`default_nettype wire

@@ sv/upcal_fifo.sv @@
// ----------------------------------------------------------------------------
// upcal_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module upcal_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire upcal_pkg::qwr_t wr,
	input  wire logic           pop,
	output upcal_pkg::qent_t    head,
	output logic                full,
	output logic                empty
);
	import upcal_pkg::*;

	qent_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr.push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr.push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

endmodule

`default_nettype wire

@@ sv/upcal_front.sv @@
// ----------------------------------------------------------------------------
// upcal_front
// Accepts events, keeps the last tick count, forms the elapsed-time product
// and queues the classified event for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module upcal_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           op,
	input  wire logic [upcal_pkg::TICK_W-1:0]   tick_count,
	input  wire logic [upcal_pkg::TMS_W-1:0]    tick_ms,
	input  wire logic                           q_full,
	output upcal_pkg::qwr_t                     q_wr
);
	import upcal_pkg::*;

	logic                valid_s1;
	op_t                 op_s1;
	logic [TICK_W-1:0]   elapsed_s1;
	logic [TICK_W-1:0]   last_tick_q;
	logic [PROD_W-1:0]   prod;
	logic                accept;

	assign prod          = PROD_W'(elapsed_s1) * PROD_W'(tick_ms);
	assign q_wr.push     = valid_s1 && !q_full;
	assign q_wr.data.op  = op_s1;
	assign q_wr.data.add = prod[TICK_W-1:0];
	assign in_ready      = !valid_s1 || q_wr.push;
	assign accept        = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_tick_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (q_wr.push) begin
				valid_s1 <= 1'b0;
			end
			if (accept && op_t'(op) == OP_TICK) begin
				last_tick_q <= tick_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op_t'(op);
			elapsed_s1 <= tick_count - last_tick_q;
		end
	end

endmodule

`default_nettype wire

@@ sv/upcal_back.sv @@
// ----------------------------------------------------------------------------
// upcal_back
// Holds the time fields. Tick updates are normalized by an iterative
// constant divider, one 8-bit digit a cycle; second ticks roll over at once.
// ----------------------------------------------------------------------------
`default_nettype none

module upcal_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire upcal_pkg::qent_t               head,
	input  wire logic                           q_empty,
	output logic                                pop,
	input  wire logic [upcal_pkg::MDAY_W-1:0]   month_days,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output upcal_pkg::res_t                     res
);
	import upcal_pkg::*;

	bk_state_t          state_q;
	bk_state_t          state_nxt;
	stage_t             stage_q;
	logic [ITER_W-1:0]  iter_q;
	logic [REM_W-1:0]   rem_q;
	logic [DVD_W-1:0]   dvd_q;

	logic [MS_W-1:0]    ms_q;
	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [DAY_BITS-1:0] day_q;
	logic [MON_W-1:0]   mon_q;
	logic [YEAR_W-1:0]  year_q;

	logic               out_valid_q;
	res_t               res_q;
	logic               out_load;

	logic [REM_W-1:0]   dvs;
	step_t              st;
	logic [DVD_W-1:0]   quot;
	logic               last_iter;

	logic [SEC_W-1:0]   sec_n;
	logic [MIN_W-1:0]   min_n;
	logic [HOUR_W-1:0]  hour_n;
	logic [DAY_BITS-1:0] day_n;
	logic [DAY_BITS-1:0] day_inc;
	logic [MON_W-1:0]   mon_n;
	logic [YEAR_W-1:0]  year_n;

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// divider datapath
	assign dvs       = div_const(stage_q);
	assign st        = div_step(rem_q, dvd_q[DVD_W-1 -: DIG_W], dvs);
	assign quot      = {dvd_q[DVD_W-DIG_W-1:0], st.q};
	assign last_iter = (iter_q == ITER_W'(DIV_ITERS - 1));

	// one-second rollover
	assign day_inc = day_q + 1'b1;
	always_comb begin
		sec_n  = sec_q + 1'b1;
		min_n  = min_q;
		hour_n = hour_q;
		day_n  = day_q;
		mon_n  = mon_q;
		year_n = year_q;
		if (sec_q >= SEC_W'(SEC_MAX)) begin
			sec_n = '0;
			min_n = min_q + 1'b1;
			if (min_q >= MIN_W'(MIN_MAX)) begin
				min_n  = '0;
				hour_n = hour_q + 1'b1;
				if (hour_q >= HOUR_W'(HOUR_MAX)) begin
					hour_n = '0;
					day_n  = day_inc;
					if (day_inc >= DAY_BITS'(month_days)) begin
						day_n = day_inc - DAY_BITS'(month_days);
						mon_n = mon_q + 1'b1;
						if (mon_q >= MON_W'(MON_MAX)) begin
							mon_n  = mon_q + 1'b1 - MON_W'(MON_PER_YEAR);
							year_n = year_q + 1'b1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		pop      = (state_q == BK_IDLE) && !q_empty;
		out_load = (state_q == BK_EMIT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_nxt = (head.op == OP_TICK) ? BK_DIV : BK_EMIT;
				end
			end
			BK_DIV: begin
				if (last_iter && stage_q == ST_HOUR) begin
					state_nxt = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_load) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_MS;
			iter_q  <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			ms_q    <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			day_q   <= '0;
			mon_q   <= '0;
			year_q  <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (pop) begin
						if (head.op == OP_TICK) begin
							dvd_q   <= DVD_W'(ms_q) + DVD_W'(head.add);
							rem_q   <= '0;
							iter_q  <= '0;
							stage_q <= ST_MS;
						end else begin
							sec_q  <= sec_n;
							min_q  <= min_n;
							hour_q <= hour_n;
							day_q  <= day_n;
							mon_q  <= mon_n;
							year_q <= year_n;
						end
					end
				end
				BK_DIV: begin
					if (!last_iter) begin
						rem_q  <= st.rem;
						dvd_q  <= quot;
						iter_q <= iter_q + 1'b1;
					end else begin
						// quotient carries into the next field
						rem_q  <= '0;
						iter_q <= '0;
						case (stage_q)
							ST_MS: begin
								ms_q    <= st.rem[MS_W-1:0];
								dvd_q   <= quot + DVD_W'(sec_q);
								stage_q <= ST_SEC;
							end
							ST_SEC: begin
								sec_q   <= st.rem[SEC_W-1:0];
								dvd_q   <= quot + DVD_W'(min_q);
								stage_q <= ST_MIN;
							end
							ST_MIN: begin
								min_q   <= st.rem[MIN_W-1:0];
								dvd_q   <= quot + DVD_W'(hour_q);
								stage_q <= ST_HOUR;
							end
							ST_HOUR: begin
								hour_q  <= st.rem[HOUR_W-1:0];
								day_q   <= day_q + DAY_BITS'(quot);
								stage_q <= ST_MS;
							end
							default: stage_q <= ST_MS;
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.millis  <= ms_q;
			res_q.seconds <= sec_q;
			res_q.minutes <= min_q;
			res_q.hours   <= hour_q;
			res_q.days    <= DAYO_W'(day_q);
			res_q.months  <= mon_q;
			res_q.years   <= year_q;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < dvs))
		else $error("divider remainder out of range");

	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ms_q < MS_W'(MS_PER_SEC)) && (sec_q < SEC_W'(SEC_PER_MIN)) &&
		(min_q < MIN_W'(MIN_PER_HOUR)) && (hour_q < HOUR_W'(HOUR_PER_DAY)) &&
		(mon_q < MON_W'(MON_PER_YEAR)))
		else $error("time field out of range");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_DIV || state_q == BK_EMIT))
		else $error("event taken from queue without being processed");

endmodule

`default_nettype wire

@@ sv/uptime_calendar_counter_top.sv @@
// ----------------------------------------------------------------------------
// uptime_calendar_counter_top
// Up-time and calendar counter: tick-count updates and one-second ticks.
// ----------------------------------------------------------------------------
// Path: an event passes the front register, the queue, the back end (rollover
//   for a second tick, divider for a tick-count update) and the output register.
// Flow: the back end takes one queued event at a time, the next only once the
//   result is loaded; the divider does four constant divisions of 5 digits.
// Reset: arst_n clears all time fields and the stored tick count to zero,
//   tick_ms to 1 and month_days to 30; no clearing pass.
`default_nettype none

module uptime_calendar_counter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           op,
	input  wire logic [upcal_pkg::TICK_W-1:0]   tick_count,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [upcal_pkg::MS_W-1:0]          millis,
	output logic [upcal_pkg::SEC_W-1:0]         seconds,
	output logic [upcal_pkg::MIN_W-1:0]         minutes,
	output logic [upcal_pkg::HOUR_W-1:0]        hours,
	output logic [upcal_pkg::DAYO_W-1:0]        days,
	output logic [upcal_pkg::MON_W-1:0]         months,
	output logic [upcal_pkg::YEAR_W-1:0]        years,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic                           cfg_index,
	input  wire logic [upcal_pkg::CDATA_W-1:0]  cfg_data
);
	import upcal_pkg::*;

	logic [TMS_W-1:0]  tick_ms_q;
	logic [MDAY_W-1:0] month_days_q;
	qwr_t              q_wr;
	qent_t             q_head;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	res_t              res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q    <= TMS_W'(1);
			month_days_q <= MDAY_W'(30);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TICK_MS:    tick_ms_q    <= cfg_data[TMS_W-1:0];
				REG_MONTH_DAYS: month_days_q <= cfg_data[MDAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	upcal_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.tick_count (tick_count),
		.tick_ms    (tick_ms_q),
		.q_full     (q_full),
		.q_wr       (q_wr)
	);

	upcal_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	upcal_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_empty    (q_empty),
		.pop        (q_pop),
		.month_days (month_days_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign millis  = res.millis;
	assign seconds = res.seconds;
	assign minutes = res.minutes;
	assign hours   = res.hours;
	assign days    = res.days;
	assign months  = res.months;
	assign years   = res.years;

endmodule

`default_nettype wire

@@ dv/uptime_calendar_counter_top_test.sv @@
// ----------------------------------------------------------------------------
// uptime_calendar_counter_top_test
// Self-checking bench for the up-time calendar counter. Tick-count updates and
// one-second ticks go in through a valid/ready driver. A clocked monitor keeps
// its own copy of the running time and compares every result field against it.
// The run steps through several tick_ms and month_days settings, including
// zero values, and pushes day, month and day-counter rollovers.
// ----------------------------------------------------------------------------
module uptime_calendar_counter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import upcal_pkg::*;

	localparam int unsigned MS_PER_MINUTE  = 60_000;
	localparam int unsigned MS_PER_HOUR    = 3_600_000;
	localparam int unsigned MS_PER_DAY     = 86_400_000;
	localparam int unsigned LAND_BEFORE_MS = 500;
	// 65537 * 65535 = 2^32 - 1: the largest update one event can add
	localparam logic [TICK_W-1:0] FULL_GAP = 32'd65537;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int PHASE_EVENTS   = 110;

	typedef struct packed {
		logic [TICK_W-1:0]   last_tick;
		logic [MS_W-1:0]     ms;
		logic [SEC_W-1:0]    sec;
		logic [MIN_W-1:0]    mins;
		logic [HOUR_W-1:0]   hrs;
		logic [DAY_BITS-1:0] day;
		logic [MON_W-1:0]    mon;
		logic [YEAR_W-1:0]   yr;
	} wall_clock_t;

	typedef struct packed {
		op_t                 kind;
		logic [TICK_W-1:0]   now;
	} clock_event_t;

	typedef struct packed {
		reg_idx_t            idx;
		logic [CDATA_W-1:0]  data;
	} cfg_write_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	op_t                 op = OP_TICK;
	logic [TICK_W-1:0]   tick_count = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [MS_W-1:0]     millis;
	logic [SEC_W-1:0]    seconds;
	logic [MIN_W-1:0]    minutes;
	logic [HOUR_W-1:0]   hours;
	logic [DAYO_W-1:0]   days;
	logic [MON_W-1:0]    months;
	logic [YEAR_W-1:0]   years;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	reg_idx_t            cfg_index = REG_TICK_MS;
	logic [CDATA_W-1:0]  cfg_data = '0;

	logic                in_xfer = 1'b0;
	logic                cfg_xfer = 1'b0;

	clock_event_t        event_q[$];
	cfg_write_t          cfg_q[$];
	wall_clock_t         due_times[$];

	// live copy follows transfers; plan copy runs ahead to shape stimulus
	wall_clock_t         live_clk = '0;
	logic [TMS_W-1:0]    live_tick_ms = 16'd1;
	logic [MDAY_W-1:0]   live_mdays = 5'd30;
	wall_clock_t         plan_clk = '0;
	logic [TMS_W-1:0]    plan_tick_ms = 16'd1;
	logic [MDAY_W-1:0]   plan_mdays = 5'd30;

	int                  idle_pct = 10;
	int                  hold_reqs = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;
	int                  fail_count = 0;

	uptime_calendar_counter_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.tick_count (tick_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.millis     (millis),
		.seconds    (seconds),
		.minutes    (minutes),
		.hours      (hours),
		.days       (days),
		.months     (months),
		.years      (years),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic wall_clock_t advance_clock(wall_clock_t c, op_t kind,
			logic [TICK_W-1:0] now, logic [TMS_W-1:0] ms_per_tick,
			logic [MDAY_W-1:0] days_in_month);
		logic [TICK_W-1:0] elapsed;
		logic [TICK_W-1:0] add_ms;
		longint unsigned   carry;
		wall_clock_t       n;
		n = c;
		if (kind == OP_TICK) begin
			elapsed = now - c.last_tick;
			add_ms = elapsed * ms_per_tick;  // product kept modulo 2^32
			n.last_tick = now;
			carry = 64'(c.ms) + 64'(add_ms);
			n.ms = MS_W'(carry % MS_PER_SEC);
			carry = carry / MS_PER_SEC + c.sec;
			n.sec = SEC_W'(carry % SEC_PER_MIN);
			carry = carry / SEC_PER_MIN + c.mins;
			n.mins = MIN_W'(carry % MIN_PER_HOUR);
			carry = carry / MIN_PER_HOUR + c.hrs;
			n.hrs = HOUR_W'(carry % HOUR_PER_DAY);
			n.day = c.day + DAY_BITS'(carry / HOUR_PER_DAY);
		end else if (c.sec < SEC_MAX) begin
			n.sec = c.sec + 1'b1;
		end else begin
			n.sec = '0;
			if (c.mins < MIN_MAX) begin
				n.mins = c.mins + 1'b1;
			end else begin
				n.mins = '0;
				if (c.hrs < HOUR_MAX) begin
					n.hrs = c.hrs + 1'b1;
				end else begin
					n.hrs = '0;
					n.day = c.day + 1'b1;
					// one subtraction only, even when the day count is far past the month
					if (n.day >= days_in_month) begin
						n.day = n.day - days_in_month;
						if (c.mon >= MON_MAX) begin
							n.mon = '0;
							n.yr = c.yr + 1'b1;
						end else begin
							n.mon = c.mon + 1'b1;
						end
					end
				end
			end
		end
		return n;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// monitor: config and input transfers update the live time, results are checked
	always @(posedge clk) begin : watch
		wall_clock_t want;
		in_xfer <= in_valid && in_ready;
		cfg_xfer <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TICK_MS)
					live_tick_ms = cfg_data[TMS_W-1:0];
				else
					live_mdays = cfg_data[MDAY_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (due_times.size() == 0) begin
					$display("%0t: result with none expected, actual %0d.%0d:%0d:%0d d%0d m%0d y%0d",
						$time, millis, seconds, minutes, hours, days, months, years);
					fail_count++;
				end else begin
					want = due_times.pop_front();
					check_field("millis", want.ms, millis);
					check_field("seconds", want.sec, seconds);
					check_field("minutes", want.mins, minutes);
					check_field("hours", want.hrs, hours);
					check_field("days", want.day[DAYO_W-1:0], days);
					check_field("months", want.mon, months);
					check_field("years", want.yr, years);
				end
			end
			if (in_valid && in_ready) begin
				live_clk = advance_clock(live_clk, op, tick_count, live_tick_ms, live_mdays);
				due_times.push_back(live_clk);
			end
		end
	end

	always @(negedge clk) begin : send_events
		clock_event_t ev;
		if (arst_n && (!in_valid || in_xfer)) begin
			if (event_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				ev = event_q.pop_front();
				in_valid <= 1'b1;
				op <= ev.kind;
				tick_count <= ev.now;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : send_config
		cfg_write_t w;
		if (arst_n && (!cfg_valid || cfg_xfer)) begin
			if (cfg_q.size() != 0) begin
				w = cfg_q.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= w.idx;
				cfg_data <= w.data;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : pace_results
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic queue_event(op_t kind, logic [TICK_W-1:0] now);
		event_q.push_back('{kind, now});
		plan_clk = advance_clock(plan_clk, kind, now, plan_tick_ms, plan_mdays);
	endtask

	// tick update that lands shortly before the end of the current or next minute, hour or day
	task automatic queue_span_end(int unsigned span);
		int unsigned       into;
		int unsigned       need;
		logic [TICK_W-1:0] gap;
		into = ((plan_clk.hrs * 60 + plan_clk.mins) * 60 + plan_clk.sec) * 1000 + plan_clk.ms;
		into = into % span;
		if (span - LAND_BEFORE_MS > into)
			need = span - LAND_BEFORE_MS - into;
		else
			need = 2 * span - LAND_BEFORE_MS - into;
		gap = (plan_tick_ms == 0) ? $urandom : need / plan_tick_ms;
		queue_event(OP_TICK, plan_clk.last_tick + gap);
	endtask

	task automatic queue_random_event();
		int pick;
		int unsigned span;
		pick = $urandom_range(99);
		if (pick < 35) begin
			queue_event(OP_SEC, $urandom);
		end else if (pick < 60) begin
			queue_event(OP_TICK, plan_clk.last_tick + $urandom_range(3000));
		end else if (pick < 70) begin
			queue_event(OP_TICK, $urandom);
		end else if (pick < 78) begin
			queue_event(OP_TICK, plan_clk.last_tick);
		end else begin
			case ($urandom_range(2))
				0:       span = MS_PER_MINUTE;
				1:       span = MS_PER_HOUR;
				default: span = MS_PER_DAY;
			endcase
			queue_span_end(span);
			repeat ($urandom_range(1, 3)) queue_event(OP_SEC, $urandom);
		end
	endtask

	task automatic set_config(logic [TMS_W-1:0] ms_per_tick, logic [MDAY_W-1:0] month_len);
		logic [CDATA_W-1:0] wdata;
		wdata = CDATA_W'($urandom);
		wdata[MDAY_W-1:0] = month_len;
		cfg_q.push_back('{REG_TICK_MS, CDATA_W'(ms_per_tick)});
		cfg_q.push_back('{REG_MONTH_DAYS, wdata});
		plan_tick_ms = ms_per_tick;
		plan_mdays = month_len;
		while (cfg_q.size() != 0 || cfg_valid) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (event_q.size() != 0 || in_valid || due_times.size() != 0) @(posedge clk);
	endtask

	task automatic queue_random_run(int count);
		repeat (count) queue_random_event();
	endtask

	initial begin : stimulus
		logic [DAY_BITS-1:0] prev_day;
		bit wrapped;
		int extra;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: field extremes, tick wrap, minute, hour and day rollover chains
		queue_event(OP_SEC, '0);
		queue_event(OP_TICK, '0);
		queue_event(OP_TICK, 32'd999);
		queue_event(OP_TICK, 32'd1000);
		queue_event(OP_TICK, '1);
		queue_event(OP_TICK, '0);
		queue_event(OP_TICK, 32'hAAAA_AAAA);
		queue_event(OP_TICK, 32'h5555_5555);
		queue_event(OP_SEC, '1);
		queue_span_end(MS_PER_MINUTE);
		queue_event(OP_SEC, 32'h0F0F_0F0F);
		queue_span_end(MS_PER_HOUR);
		queue_event(OP_SEC, 32'hF0F0_F0F0);
		queue_span_end(MS_PER_DAY);
		queue_event(OP_SEC, '0);
		queue_event(OP_SEC, '0);
		wait_drained();

		// largest tick_ms: push the day counter through its wrap
		set_config('1, 5'd31);
		wrapped = 1'b0;
		extra = 0;
		for (int i = 0; i < 2000 && extra < 20; i++) begin
			prev_day = plan_clk.day;
			if ($urandom_range(99) < 95)
				queue_event(OP_TICK, plan_clk.last_tick + FULL_GAP);
			else
				queue_random_event();
			if (prev_day > 16'hF000 && plan_clk.day < 16'h1000)
				wrapped = 1'b1;
			if (wrapped)
				extra++;
		end
		wait_drained();

		// long receiver stall while the sender keeps offering
		set_config(16'd1, 5'd28);
		queue_random_run(PHASE_EVENTS);
		hold_reqs++;
		wait_drained();

		// zero tick_ms: updates only move the stored tick
		set_config('0, 5'd30);
		queue_random_run(PHASE_EVENTS);
		wait_drained();

		// zero month length, no idling on either side
		idle_pct = 0;
		set_config(TMS_W'($urandom_range(1, 500)), '0);
		queue_random_run(PHASE_EVENTS);
		wait_drained();
		idle_pct = 10;

		// sender pauses halfway until all results are back
		set_config(16'd1000, 5'd1);
		queue_random_run(PHASE_EVENTS / 2);
		wait_drained();
		queue_random_run(PHASE_EVENTS / 2);
		wait_drained();

		set_config(TMS_W'($urandom_range(1, 65535)), MDAY_W'($urandom_range(0, 31)));
		queue_random_run(PHASE_EVENTS);
		wait_drained();

		set_config(TMS_W'($urandom_range(1, 300)), 5'd29);
		queue_random_run(PHASE_EVENTS);
		wait_drained();

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#(10_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ uptime_calendar_counter_top.f @@
sv/upcal_pkg.sv
sv/upcal_fifo.sv
sv/upcal_front.sv
sv/upcal_back.sv
sv/uptime_calendar_counter_top.sv
dv/uptime_calendar_counter_top_test.sv
